>>> rtl/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle property, checked outside reset
`define ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent now, consequent on the next clock
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_NOW(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/ps2dl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ps2dl_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] HOLDOFF_RESET = 8'd8;

	typedef enum logic [1:0] {
		CMD_EDGE  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_QUEUE = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		EDGE_NONE = 2'd0,
		EDGE_FALL = 2'd1,
		EDGE_RISE = 2'd2
	} edge_t;

	typedef enum logic [4:0] {
		PH_IDLE         = 5'd0,
		PH_PREP_START   = 5'd1,
		PH_SEND_START   = 5'd2,
		PH_PREP_BIT     = 5'd3,
		PH_SEND_BIT     = 5'd4,
		PH_PREP_PARITY  = 5'd5,
		PH_SEND_PARITY  = 5'd6,
		PH_PREP_STOP    = 5'd7,
		PH_SEND_STOP    = 5'd8,
		PH_HOLDOFF      = 5'd9,
		PH_HOST_INHIBIT = 5'd10,
		PH_WAIT_START   = 5'd11,
		PH_GET_START    = 5'd12,
		PH_WAIT_BIT     = 5'd13,
		PH_GET_BIT      = 5'd14,
		PH_GET_PARITY   = 5'd15,
		PH_WAIT_STOP    = 5'd16,
		PH_WAIT_ACK     = 5'd17,
		PH_GET_ACK      = 5'd18
	} phase_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic nonempty;
		logic full;
		logic full_next;
	} q_stat_t;

	typedef struct packed {
		logic       clk_drive;
		logic       data_drive;
		logic       timer_armed;
		logic [1:0] edge_watch;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       tx_committed;
		logic       queue_full;
		logic [4:0] link_state;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/ps2dl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ps2dl_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ps2dl_pkg::q_ctl_t ctl,
	input  wire logic [7:0]        wr_data,
	output ps2dl_pkg::q_stat_t     stat,
	output logic [7:0]             head_data
);
	import ps2dl_pkg::*;

	logic [7:0]        mem_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] head_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W-1:0] count_d;
	logic [QIDX_W:0]   slot_sum;
	logic [QIDX_W-1:0] wr_idx;
	logic [QIDX_W-1:0] head_inc;

	// tail slot wraps past the end of the ring
	always_comb begin
		slot_sum = {1'b0, head_q} + {1'b0, count_q[QIDX_W-1:0]};
		if (slot_sum >= (QIDX_W + 1)'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - (QIDX_W + 1)'(QUEUE_DEPTH);
		end
		wr_idx = slot_sum[QIDX_W-1:0];
		if (head_q == QIDX_W'(QUEUE_DEPTH - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + QIDX_W'(1);
		end
	end

	always_comb begin
		count_d = count_q;
		if (ctl.push) begin
			count_d = count_q + QCNT_W'(1);
		end else if (ctl.pop) begin
			count_d = count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (ctl.pop) begin
				head_q <= head_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	assign head_data      = mem_q[head_q];
	assign stat.nonempty  = (count_q != '0);
	assign stat.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.full_next = (count_d == QCNT_W'(QUEUE_DEPTH));

	`ASSERT_NOW(a_count_bound, clk, arst_n, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
	`ASSERT_NOW(a_pop_nonempty, clk, arst_n, !ctl.pop || count_q != '0, "pop from empty queue")

endmodule

`default_nettype wire

>>> rtl/ps2dl_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ps2dl_fsm (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire ps2dl_pkg::cmd_t    cmd,
	input  wire logic               clk_line,
	input  wire logic               data_line,
	input  wire logic [7:0]         holdoff_ticks,
	input  wire ps2dl_pkg::q_stat_t qstat,
	input  wire logic [7:0]         head_data,
	output ps2dl_pkg::q_ctl_t       qctl,
	output ps2dl_pkg::res_t         res
);
	import ps2dl_pkg::*;

	phase_t     phase_q, phase_d;
	edge_t      edge_q, edge_d;
	logic [3:0] cnt_q, cnt_d;
	logic [7:0] shift_q, shift_d;
	logic       par_q, par_d;
	logic [7:0] hold_q, hold_d;
	logic       clk_q, clk_d;
	logic       dat_q, dat_d;
	logic       tmr_q, tmr_d;
	logic [7:0] hold_dec;
	logic       tick_en;

	assign tick_en  = step && (cmd == CMD_TICK) && tmr_q;
	assign hold_dec = hold_q - 8'd1;

	// next state
	always_comb begin
		phase_d = phase_q;
		edge_d  = edge_q;
		cnt_d   = cnt_q;
		shift_d = shift_q;
		par_d   = par_q;
		hold_d  = hold_q;
		clk_d   = clk_q;
		dat_d   = dat_q;
		tmr_d   = tmr_q;
		if (step) begin
			case (cmd)
				CMD_EDGE: begin
					if (edge_q != EDGE_NONE) begin
						edge_d = EDGE_NONE;
						if (phase_q == PH_IDLE || phase_q == PH_PREP_START) begin
							tmr_d   = 1'b0;
							edge_d  = EDGE_RISE;
							phase_d = PH_HOST_INHIBIT;
							dat_d   = 1'b1;
						end else if (phase_q == PH_HOST_INHIBIT) begin
							if (data_line) begin
								if (qstat.nonempty) begin
									tmr_d   = 1'b1;
									dat_d   = 1'b0;
									phase_d = PH_PREP_START;
								end else begin
									phase_d = PH_IDLE;
									tmr_d   = 1'b0;
									edge_d  = EDGE_FALL;
								end
							end else begin
								tmr_d   = 1'b1;
								phase_d = PH_WAIT_START;
							end
						end
					end
				end
				CMD_TICK: begin
					if (tmr_q) begin
						case (phase_q)
							PH_PREP_START: begin
								edge_d  = EDGE_NONE;
								clk_d   = 1'b0;
								phase_d = PH_SEND_START;
							end
							PH_SEND_START: begin
								clk_d = 1'b1;
								if (clk_line) begin
									dat_d   = head_data[0];
									par_d   = ~head_data[0];
									shift_d = {1'b0, head_data[7:1]};
									cnt_d   = 4'd1;
									phase_d = PH_PREP_BIT;
								end else begin
									shift_d = head_data;
									cnt_d   = 4'd0;
									par_d   = 1'b1;
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end
							end
							PH_PREP_BIT, PH_PREP_PARITY, PH_PREP_STOP: begin
								clk_d = 1'b0;
								case (phase_q)
									PH_PREP_BIT:    phase_d = PH_SEND_BIT;
									PH_PREP_PARITY: phase_d = PH_SEND_PARITY;
									default:        phase_d = PH_SEND_STOP;
								endcase
							end
							PH_SEND_BIT: begin
								clk_d = 1'b1;
								if (!clk_line) begin
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end else if (cnt_q == 4'd8) begin
									dat_d   = par_q;
									phase_d = PH_PREP_PARITY;
								end else begin
									dat_d   = shift_q[0];
									par_d   = par_q ^ shift_q[0];
									shift_d = {1'b0, shift_q[7:1]};
									cnt_d   = cnt_q + 4'd1;
									phase_d = PH_PREP_BIT;
								end
							end
							PH_SEND_PARITY: begin
								clk_d = 1'b1;
								if (clk_line) begin
									dat_d   = 1'b1;
									phase_d = PH_PREP_STOP;
								end else begin
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end
							end
							PH_SEND_STOP: begin
								clk_d = 1'b1;
								if (!clk_line) begin
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end else if (data_line) begin
									hold_d  = holdoff_ticks;
									phase_d = PH_HOLDOFF;
								end else begin
									phase_d = PH_WAIT_START;
								end
							end
							PH_WAIT_START: begin
								cnt_d   = 4'd0;
								shift_d = 8'd0;
								par_d   = 1'b1;
								if (data_line) begin
									// host released data: no request after all
									clk_d   = 1'b1;
									phase_d = PH_IDLE;
									tmr_d   = 1'b0;
									edge_d  = EDGE_FALL;
								end else begin
									clk_d   = 1'b0;
									phase_d = PH_GET_START;
								end
							end
							PH_GET_START: begin
								clk_d = 1'b1;
								if (clk_line) begin
									phase_d = PH_WAIT_BIT;
								end else begin
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end
							end
							PH_WAIT_BIT: begin
								clk_d   = 1'b0;
								shift_d = {data_line, shift_q[7:1]};
								par_d   = par_q ^ data_line;
								cnt_d   = cnt_q + 4'd1;
								phase_d = PH_GET_BIT;
							end
							PH_GET_BIT: begin
								clk_d = 1'b1;
								if (!clk_line) begin
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end else if (cnt_q == 4'd8) begin
									phase_d = PH_GET_PARITY;
								end else begin
									phase_d = PH_WAIT_BIT;
								end
							end
							PH_GET_PARITY: begin
								clk_d   = 1'b0;
								phase_d = PH_WAIT_STOP;
							end
							PH_WAIT_STOP: begin
								clk_d = 1'b1;
								if (!clk_line) begin
									tmr_d   = 1'b0;
									edge_d  = EDGE_RISE;
									phase_d = PH_HOST_INHIBIT;
									dat_d   = 1'b1;
								end else if (data_line) begin
									phase_d = PH_WAIT_ACK;
									dat_d   = 1'b0;
								end else begin
									// no stop bit yet, clock one more
									phase_d = PH_GET_PARITY;
								end
							end
							PH_WAIT_ACK: begin
								clk_d   = 1'b0;
								phase_d = PH_GET_ACK;
							end
							PH_GET_ACK: begin
								clk_d   = 1'b1;
								dat_d   = 1'b1;
								hold_d  = 8'd1;
								phase_d = PH_HOLDOFF;
							end
							PH_HOLDOFF: begin
								hold_d = hold_dec;
								if (hold_dec == 8'd0) begin
									if (!clk_line) begin
										tmr_d   = 1'b0;
										edge_d  = EDGE_RISE;
										phase_d = PH_HOST_INHIBIT;
										dat_d   = 1'b1;
									end else if (data_line) begin
										if (qstat.nonempty) begin
											tmr_d   = 1'b1;
											dat_d   = 1'b0;
											phase_d = PH_PREP_START;
										end else begin
											phase_d = PH_IDLE;
											tmr_d   = 1'b0;
											edge_d  = EDGE_FALL;
										end
									end else begin
										phase_d = PH_WAIT_START;
									end
								end
							end
							default: begin
								tmr_d = 1'b0;
							end
						endcase
					end
				end
				CMD_QUEUE: begin
					if (!qstat.full && phase_q == PH_IDLE) begin
						tmr_d   = 1'b1;
						dat_d   = 1'b0;
						phase_d = PH_PREP_START;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		qctl.push        = step && (cmd == CMD_QUEUE) && !qstat.full;
		qctl.pop         = tick_en && (phase_q == PH_SEND_STOP) && qstat.nonempty;
		res.clk_drive    = clk_d;
		res.data_drive   = dat_d;
		res.timer_armed  = tmr_d;
		res.edge_watch   = edge_d;
		res.rx_valid     = tick_en && (phase_q == PH_GET_ACK);
		res.rx_byte      = res.rx_valid ? shift_q : 8'd0;
		res.tx_committed = qctl.pop;
		res.queue_full   = qstat.full_next;
		res.link_state   = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			edge_q  <= EDGE_FALL;
			cnt_q   <= 4'd0;
			shift_q <= 8'd0;
			par_q   <= 1'b1;
			hold_q  <= 8'd0;
			clk_q   <= 1'b1;
			dat_q   <= 1'b1;
			tmr_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			edge_q  <= edge_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			par_q   <= par_d;
			hold_q  <= hold_d;
			clk_q   <= clk_d;
			dat_q   <= dat_d;
			tmr_q   <= tmr_d;
		end
	end

	`ASSERT_NEXT(a_rx_holdoff, clk, arst_n, res.rx_valid, phase_q == PH_HOLDOFF && hold_q == 8'd1, "receive did not enter holdoff")
	`ASSERT_NOW(a_commit_stop, clk, arst_n, !res.tx_committed || phase_q == PH_SEND_STOP, "commit outside stop bit")

endmodule

`default_nettype wire

>>> rtl/ps2_device_link_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// PS/2 device-side link engine. Each input beat is one event: a CLK edge, a
// half-cycle timer tick, a byte to queue for sending (16-entry queue, a byte
// offered while full is dropped), or a no-op. Every beat yields exactly one
// result beat carrying the line drives, timer and edge requests, any received
// host byte, the commit flag, the queue-full flag and the protocol state. A
// beat is registered on entry and processed by the protocol state machine once
// the output slot is empty or draining, and its result is registered there.
// One beat is taken per clock while the output is not stalled. holdoff_ticks
// may only be written while no beat is in flight.
module ps2_device_link_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] command,
	input  wire logic       clk_line,
	input  wire logic       data_line,
	input  wire logic [7:0] tx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            clk_drive,
	output logic            data_drive,
	output logic            timer_armed,
	output logic [1:0]      edge_watch,
	output logic            rx_valid,
	output logic [7:0]      rx_byte,
	output logic            tx_committed,
	output logic            queue_full,
	output logic [4:0]      link_state
);
	import ps2dl_pkg::*;

	logic [7:0] holdoff_ticks_q;
	logic       v_s1;
	logic [1:0] cmd_s1;
	logic       clk_s1;
	logic       dat_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res;
	q_ctl_t     qctl;
	q_stat_t    qstat;
	logic [7:0] head_data;
	logic       advance;

	// the step runs when the output slot is empty or draining this cycle
	assign advance  = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_ticks_q <= HOLDOFF_RESET;
			v_s1            <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				holdoff_ticks_q <= cfg_wr_data;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			clk_s1  <= clk_line;
			dat_s1  <= data_line;
			byte_s1 <= tx_byte;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	ps2dl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (qctl),
		.wr_data   (byte_s1),
		.stat      (qstat),
		.head_data (head_data)
	);

	ps2dl_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.cmd           (cmd_t'(cmd_s1)),
		.clk_line      (clk_s1),
		.data_line     (dat_s1),
		.holdoff_ticks (holdoff_ticks_q),
		.qstat         (qstat),
		.head_data     (head_data),
		.qctl          (qctl),
		.res           (res)
	);

	assign out_valid    = out_valid_q;
	assign clk_drive    = res_q.clk_drive;
	assign data_drive   = res_q.data_drive;
	assign timer_armed  = res_q.timer_armed;
	assign edge_watch   = res_q.edge_watch;
	assign rx_valid     = res_q.rx_valid;
	assign rx_byte      = res_q.rx_byte;
	assign tx_committed = res_q.tx_committed;
	assign queue_full   = res_q.queue_full;
	assign link_state   = res_q.link_state;

	`ASSERT_NOW(a_ready_when_free, clk, arst_n, out_valid_q || in_ready, "input stalled with empty output slot")
	`ASSERT_NEXT(a_cfg_taken, clk, arst_n, cfg_wr_en, holdoff_ticks_q == $past(cfg_wr_data), "config write lost")

endmodule

`default_nettype wire
